/* hdl/y2r_pkg.sv */
// ============================================================================
// y2r_pkg - shared types and constants for the YUYV to RGB565 converter
// Fixed-point BT.601 coefficients (scaled by 2^16, rounded) and the
// payload structs carried between pipeline stages.
// ============================================================================
package y2r_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ACC_W     = 28;   // holds any product or channel sum
    localparam int OFS_W     = 9;    // signed offset sample width

    typedef logic signed [OFS_W-1:0] t_ofs;
    typedef logic signed [ACC_W-1:0] t_acc;

    localparam t_acc COEF_Y  = t_acc'(76284);
    localparam t_acc COEF_RV = t_acc'(104595);
    localparam t_acc COEF_GV = t_acc'(53281);
    localparam t_acc COEF_GU = t_acc'(25625);
    localparam t_acc COEF_BU = t_acc'(132252);

    localparam t_ofs LUMA_OFS   = t_ofs'(16);
    localparam t_ofs CHROMA_OFS = t_ofs'(128);
    localparam logic [7:0] CHAN_MAX = 8'hFF;

    // Offset-removed samples
    typedef struct packed {
        t_ofs y1;
        t_ofs y2;
        t_ofs u;
        t_ofs v;
        logic last;
    } t_ofs_beat;

    // Weighted terms
    typedef struct packed {
        t_acc ys1;
        t_acc ys2;
        t_acc rv;
        t_acc gv;
        t_acc gu;
        t_acc bu;
        logic last;
    } t_prod_beat;

    // Unclamped channel sums for both pixels
    typedef struct packed {
        t_acc r1;
        t_acc g1;
        t_acc b1;
        t_acc r2;
        t_acc g2;
        t_acc b2;
        logic last;
    } t_sum_beat;

endpackage

/* hdl/y2r_offset.sv */
// ============================================================================
// y2r_offset - stage 1: remove luma and chroma offsets
// Registers signed y - 16, u - 128 and v - 128 for one macropixel.
// ============================================================================
module y2r_offset (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_y1,
    input  logic [7:0]           i_u,
    input  logic [7:0]           i_y2,
    input  logic [7:0]           i_v,
    input  logic                 i_last,
    output logic                 o_valid,
    input  logic                 i_ready,
    output y2r_pkg::t_ofs_beat   o_beat
);

    logic                r_valid;
    y2r_pkg::t_ofs_beat  r_beat;
    y2r_pkg::t_ofs_beat  n_beat;

    always_comb begin
        n_beat.y1   = $signed({1'b0, i_y1}) - y2r_pkg::LUMA_OFS;
        n_beat.y2   = $signed({1'b0, i_y2}) - y2r_pkg::LUMA_OFS;
        n_beat.u    = $signed({1'b0, i_u}) - y2r_pkg::CHROMA_OFS;
        n_beat.v    = $signed({1'b0, i_v}) - y2r_pkg::CHROMA_OFS;
        n_beat.last = i_last;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

/* hdl/y2r_mult.sv */
// ============================================================================
// y2r_mult - stage 2: coefficient products
// Six constant multiplies, one per weighted term, each registered.
// ============================================================================
module y2r_mult (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  y2r_pkg::t_ofs_beat   i_beat,
    output logic                 o_valid,
    input  logic                 i_ready,
    output y2r_pkg::t_prod_beat  o_beat
);

    logic                 r_valid;
    y2r_pkg::t_prod_beat  r_beat;
    y2r_pkg::t_prod_beat  n_beat;

    always_comb begin
        n_beat.ys1  = y2r_pkg::t_acc'(i_beat.y1) * y2r_pkg::COEF_Y;
        n_beat.ys2  = y2r_pkg::t_acc'(i_beat.y2) * y2r_pkg::COEF_Y;
        n_beat.rv   = y2r_pkg::t_acc'(i_beat.v) * y2r_pkg::COEF_RV;
        n_beat.gv   = y2r_pkg::t_acc'(i_beat.v) * y2r_pkg::COEF_GV;
        n_beat.gu   = y2r_pkg::t_acc'(i_beat.u) * y2r_pkg::COEF_GU;
        n_beat.bu   = y2r_pkg::t_acc'(i_beat.u) * y2r_pkg::COEF_BU;
        n_beat.last = i_beat.last;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

/* hdl/y2r_sum.sv */
// ============================================================================
// y2r_sum - stage 3: channel sums
// Combines luma and chroma terms into unclamped R, G, B for both pixels.
// ============================================================================
module y2r_sum (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  y2r_pkg::t_prod_beat  i_beat,
    output logic                 o_valid,
    input  logic                 i_ready,
    output y2r_pkg::t_sum_beat   o_beat
);

    logic                r_valid;
    y2r_pkg::t_sum_beat  r_beat;
    y2r_pkg::t_sum_beat  n_beat;

    always_comb begin
        n_beat.r1   = i_beat.ys1 + i_beat.rv;
        n_beat.g1   = i_beat.ys1 - i_beat.gv - i_beat.gu;
        n_beat.b1   = i_beat.ys1 + i_beat.bu;
        n_beat.r2   = i_beat.ys2 + i_beat.rv;
        n_beat.g2   = i_beat.ys2 - i_beat.gv - i_beat.gu;
        n_beat.b2   = i_beat.ys2 + i_beat.bu;
        n_beat.last = i_beat.last;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

/* hdl/y2r_pack.sv */
// ============================================================================
// y2r_pack - stage 4: clamp and pack
// Floor-shifts each sum, saturates to 0..255 and packs RGB565; this is the
// output register of the block.
// ============================================================================
module y2r_pack (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  y2r_pkg::t_sum_beat  i_beat,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [15:0]         o_pixel1,
    output logic [15:0]         o_pixel2,
    output logic                o_last
);

    localparam int Q_W = y2r_pkg::ACC_W - y2r_pkg::FRAC_BITS;

    function automatic logic [7:0] clamp_chan(input y2r_pkg::t_acc sum);
        logic [Q_W-1:0] q;
        q = sum[y2r_pkg::ACC_W-1:y2r_pkg::FRAC_BITS];
        if (sum < 0) begin
            clamp_chan = 8'd0;
        end else if (q > Q_W'(y2r_pkg::CHAN_MAX)) begin
            clamp_chan = y2r_pkg::CHAN_MAX;
        end else begin
            clamp_chan = q[7:0];
        end
    endfunction

    function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        pack565 = {r[7:3], g[7:2], b[7:3]};
    endfunction

    logic        r_valid;
    logic [15:0] r_pixel1;
    logic [15:0] r_pixel2;
    logic        r_last;
    logic [15:0] n_pixel1;
    logic [15:0] n_pixel2;

    always_comb begin
        n_pixel1 = pack565(clamp_chan(i_beat.r1), clamp_chan(i_beat.g1),
                           clamp_chan(i_beat.b1));
        n_pixel2 = pack565(clamp_chan(i_beat.r2), clamp_chan(i_beat.g2),
                           clamp_chan(i_beat.b2));
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pixel1 <= n_pixel1;
            r_pixel2 <= n_pixel2;
            r_last   <= i_beat.last;
        end
    end

    assign o_valid  = r_valid;
    assign o_pixel1 = r_pixel1;
    assign o_pixel2 = r_pixel2;
    assign o_last   = r_last;

endmodule

/* hdl/yuyv_to_rgb565.sv */
// Beats pass four registered stages; each stage refills in the cycle it drains.
// Throughput: one macropixel per cycle while the output is not stalled.
// Any stage holding a beat stalls only when the stage after it is full and stalled.
// Reset (i_rst_n low, synchronous) empties all four stages; payload is not cleared.
// ============================================================================
// yuyv_to_rgb565 - YUYV 4:2:2 macropixel to two RGB565 pixels, BT.601
// Four-stage pipeline: offset removal, coefficient multiply, channel sum,
// clamp and pack. The frame-end flag rides along as tlast.
// ============================================================================
module yuyv_to_rgb565 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] luma_first, [15:8] chroma_blue, [23:16] luma_second, [31:24] chroma_red
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,   // frame_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] pixel_first, [31:16] pixel_second
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast    // frame_done
);

    // Stage handshakes: each stage's ready is open when it is empty or its
    // downstream takes the held beat this cycle.
    logic                 w_ofs_valid;
    logic                 w_ofs_ready;
    y2r_pkg::t_ofs_beat   w_ofs_beat;
    logic                 w_prod_valid;
    logic                 w_prod_ready;
    y2r_pkg::t_prod_beat  w_prod_beat;
    logic                 w_sum_valid;
    logic                 w_sum_ready;
    y2r_pkg::t_sum_beat   w_sum_beat;
    logic [15:0]          w_pixel1;
    logic [15:0]          w_pixel2;

    // Stage 1: strip offsets from the four samples
    y2r_offset u_offset (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_y1    (s_axis_tdata[7:0]),
        .i_u     (s_axis_tdata[15:8]),
        .i_y2    (s_axis_tdata[23:16]),
        .i_v     (s_axis_tdata[31:24]),
        .i_last  (s_axis_tlast),
        .o_valid (w_ofs_valid),
        .i_ready (w_ofs_ready),
        .o_beat  (w_ofs_beat)
    );

    // Stage 2: one multiply per weighted term
    y2r_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ofs_valid),
        .o_ready (w_ofs_ready),
        .i_beat  (w_ofs_beat),
        .o_valid (w_prod_valid),
        .i_ready (w_prod_ready),
        .o_beat  (w_prod_beat)
    );

    // Stage 3: add the terms into raw channel sums
    y2r_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_prod_valid),
        .o_ready (w_prod_ready),
        .i_beat  (w_prod_beat),
        .o_valid (w_sum_valid),
        .i_ready (w_sum_ready),
        .o_beat  (w_sum_beat)
    );

    // Stage 4: saturate, pack and hold for the master side
    y2r_pack u_pack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_sum_valid),
        .o_ready  (w_sum_ready),
        .i_beat   (w_sum_beat),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_pixel1 (w_pixel1),
        .o_pixel2 (w_pixel2),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {w_pixel2, w_pixel1};

    // The input side may only stall when every stage holds a beat.
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (w_ofs_valid && w_prod_valid && w_sum_valid && m_axis_tvalid))
        else $error("input stalled with a bubble in the pipeline");

    // An accepted beat always lands in stage 1.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> w_ofs_valid)
        else $error("accepted beat lost at stage 1");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

/* bench/tb.sv */
// ============================================================================
// tb - self-checking bench for the YUYV to RGB565 converter
// Walks a short table of corner macropixels, then a long run of random
// beats with random source gaps and sink stalls. Each accepted input beat
// queues its predicted pair of RGB565 words and frame flag. Each output
// beat is checked in order against the oldest queued prediction.
// ============================================================================
module tb;

    // BT.601 factors in 16.16 fixed point
    localparam longint K_LUMA  = 76284;
    localparam longint K_RED_V = 104595;
    localparam longint K_GRN_V = 53281;
    localparam longint K_GRN_U = 25625;
    localparam longint K_BLU_U = 132252;
    localparam longint LUMA_BASE   = 16;
    localparam longint CHROMA_BASE = 128;

    localparam int DIR_ROWS    = 18;
    localparam int RAND_BEATS  = 1630;
    localparam int QUIET_TAIL  = 200;
    localparam int DRAIN_WAIT  = 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [15:0] px_first;
        logic [15:0] px_second;
        logic        frame_done;
    } t_rgb_pair;

    typedef struct packed {
        logic [7:0]  y1;
        logic [7:0]  u;
        logic [7:0]  y2;
        logic [7:0]  v;
        logic        last;
        logic        typed;     // expected words given in the row itself
        logic [15:0] exp1;
        logic [15:0] exp2;
    } t_dir_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    // Side band that travels with the beat on the input bus
    logic      typed_beat = 1'b0;
    t_rgb_pair typed_pair = '0;

    t_rgb_pair expected_px [$];
    int        mismatch_cnt = 0;
    int        cycle_cnt    = 0;
    int        stall_left   = 0;
    logic      sink_idle_on = 1'b0;
    logic      drain_quiet  = 1'b0;
    t_dir_row  dir_tab [DIR_ROWS];

    yuyv_to_rgb565 u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // Floor shift, then saturate to one byte; negative sums go to zero
    function automatic logic [7:0] sat_channel(input longint acc);
        longint q;
        if (acc < 0)
            return 8'd0;
        q = acc >>> 16;
        if (q > 255)
            return 8'hFF;
        return q[7:0];
    endfunction

    function automatic logic [15:0] rgb565_of(input logic [7:0] luma, input longint u,
                                              input longint v);
        longint     ys;
        logic [7:0] r, g, b;
        ys = (longint'(luma) - LUMA_BASE) * K_LUMA;
        r  = sat_channel(ys + K_RED_V * v);
        g  = sat_channel(ys - K_GRN_V * v - K_GRN_U * u);
        b  = sat_channel(ys + K_BLU_U * u);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    function automatic t_rgb_pair convert_macropixel(input logic [31:0] data,
                                                     input logic last);
        t_rgb_pair pair;
        longint    u, v;
        u = longint'(data[15:8])  - CHROMA_BASE;
        v = longint'(data[31:24]) - CHROMA_BASE;
        pair.px_first   = rgb565_of(data[7:0],   u, v);
        pair.px_second  = rgb565_of(data[23:16], u, v);
        pair.frame_done = last;
        return pair;
    endfunction

    // Bias a quarter of the samples toward range edges and clamp knees
    function automatic logic [7:0] pick_sample();
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 11))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd15;
            3:       return 8'd16;
            4:       return 8'd17;
            5:       return 8'd127;
            6:       return 8'd128;
            7:       return 8'd129;
            8:       return 8'd235;
            9:       return 8'd236;
            10:      return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    // Present one beat, with an optional random gap first; return at acceptance
    task automatic drive_beat(input logic [31:0] data, input logic last,
                              input logic idle_ok, input logic typed, input t_rgb_pair pair);
        if (idle_ok && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        typed_beat    <= typed;
        typed_pair    <= pair;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Queue the prediction on input acceptance, check on output acceptance
    always @(posedge i_clk) begin
        t_rgb_pair want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                expected_px.push_back(typed_beat ? typed_pair
                                                 : convert_macropixel(s_axis_tdata, s_axis_tlast));
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_px.size() == 0) begin
                    $display("%0t: unexpected output beat: expected none, actual %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                    mismatch_cnt++;
                end else begin
                    want = expected_px.pop_front();
                    if (m_axis_tdata[15:0] !== want.px_first) begin
                        $display("%0t: pixel_first expected %h actual %h",
                                 $time, want.px_first, m_axis_tdata[15:0]);
                        mismatch_cnt++;
                    end
                    if (m_axis_tdata[31:16] !== want.px_second) begin
                        $display("%0t: pixel_second expected %h actual %h",
                                 $time, want.px_second, m_axis_tdata[31:16]);
                        mismatch_cnt++;
                    end
                    if (m_axis_tlast !== want.frame_done) begin
                        $display("%0t: frame_done expected %b actual %b",
                                 $time, want.frame_done, m_axis_tlast);
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    // Sink: stall in bursts while busy mode is on, never in the quiet tail
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt % 128 == 0)
            sink_idle_on <= !drain_quiet && ($urandom_range(0, 2) != 0);
        if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left    <= 0;
            m_axis_tready <= 1'b1;
        end else if (sink_idle_on && !drain_quiet && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(1, 19);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int        n;
        logic      src_idle;
        t_rgb_pair row_pair;

        //            y1     u      y2     v    last typed  exp1     exp2
        dir_tab = '{
            '{8'd0,   8'd128, 8'd0,   8'd128, 1'b0, 1'b1, 16'h0000, 16'h0000},
            '{8'd255, 8'd128, 8'd255, 8'd128, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF},
            '{8'd16,  8'd128, 8'd255, 8'd128, 1'b1, 1'b1, 16'h0000, 16'hFFFF},
            '{8'd235, 8'd128, 8'd128, 8'd128, 1'b0, 1'b0, 16'h0000, 16'h0000},
            '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 16'h0000, 16'h0000},
            '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 16'h0000, 16'h0000},
            '{8'd128, 8'd0,   8'd128, 8'd0,   1'b0, 1'b0, 16'h0000, 16'h0000},
            '{8'd128, 8'd255, 8'd128, 8'd255, 1'b0, 1'b0, 16'h0000, 16'h0000},
            '{8'd128, 8'd0,   8'd128, 8'd255, 1'b0, 1'b0, 16'h0000, 16'h0000},
            '{8'd128, 8'd255, 8'd128, 8'd0,   1'b0, 1'b0, 16'h0000, 16'h0000},
            '{8'd15,  8'd128, 8'd236, 8'd128, 1'b0, 1'b0, 16'h0000, 16'h0000},
            '{8'd17,  8'd128, 8'd234, 8'd128, 1'b0, 1'b0, 16'h0000, 16'h0000},
            '{8'hAA,  8'h55,  8'hAA,  8'h55,  1'b1, 1'b0, 16'h0000, 16'h0000},
            '{8'h55,  8'hAA,  8'h55,  8'hAA,  1'b0, 1'b0, 16'h0000, 16'h0000},
            '{8'h81,  8'h7F,  8'h7E,  8'h80,  1'b0, 1'b0, 16'h0000, 16'h0000},
            '{8'd255, 8'd0,   8'd0,   8'd255, 1'b0, 1'b0, 16'h0000, 16'h0000},
            '{8'd0,   8'd255, 8'd255, 8'd0,   1'b1, 1'b0, 16'h0000, 16'h0000},
            '{8'd1,   8'd254, 8'd254, 8'd1,   1'b0, 1'b0, 16'h0000, 16'h0000}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle = ($urandom_range(0, 1) != 0);
        foreach (dir_tab[k]) begin
            row_pair = '{px_first: dir_tab[k].exp1, px_second: dir_tab[k].exp2,
                         frame_done: dir_tab[k].last};
            drive_beat({dir_tab[k].v, dir_tab[k].y2, dir_tab[k].u, dir_tab[k].y1},
                       dir_tab[k].last, src_idle, dir_tab[k].typed, row_pair);
        end

        for (n = 0; n < RAND_BEATS; n++) begin
            // Switch source gaps on and off in stretches; hold them off at the end
            if (n % 60 == 0)
                src_idle = ($urandom_range(0, 2) != 0);
            if (n >= RAND_BEATS - QUIET_TAIL) begin
                src_idle = 1'b0;
                if (n == RAND_BEATS - QUIET_TAIL)
                    drain_quiet <= 1'b1;
            end
            drive_beat({pick_sample(), pick_sample(), pick_sample(), pick_sample()},
                       ($urandom_range(0, 15) == 0), src_idle, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        typed_beat    <= 1'b0;

        @(posedge i_clk);
        while (expected_px.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
